// ===== hw/rtl/bsca_pkg.sv =====
// ----------------------------------------------------------------------------
// bsca_pkg
// Shared types, constants and codes of the size-class allocator.
// ----------------------------------------------------------------------------
package bsca_pkg;

	localparam int REGIONS_PER_CLASS = 64;
	localparam int CHUNKS_PER_REGION = 32;
	localparam int NUM_CLASSES       = 11;
	localparam int MIN_CHUNK_SHIFT   = 2;
	localparam int ADDR_BITS         = 40;

	localparam int REGION_SHIFT     = 5;
	localparam int REFILL_STEP      = 5;
	localparam int REFILL_MAX_CLASS = 5;

	localparam int TABLE_DEPTH = NUM_CLASSES * REGIONS_PER_CLASS;
	localparam int TBL_AW      = $clog2(TABLE_DEPTH);
	localparam int SLOT_W      = $clog2(REGIONS_PER_CLASS);
	localparam int CNT_W       = $clog2(REGIONS_PER_CLASS + 1);
	localparam int CLS_W       = $clog2(NUM_CLASSES + 1);
	localparam int BIT_W       = $clog2(CHUNKS_PER_REGION);

	localparam int CMD_W   = 2;
	localparam int SIZE_W  = 18;
	localparam int ST_W    = 3;
	localparam int GSIZE_W = 13;

	localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACQ = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REL = 2'd2;

	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_NOSPACE = 3'd1;
	localparam logic [ST_W-1:0] ST_BADSIZE = 3'd2;
	localparam logic [ST_W-1:0] ST_BADADDR = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [SIZE_W-1:0]    req_size;
		logic [ADDR_BITS-1:0] req_addr;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]      status;
		logic [ADDR_BITS-1:0] grant_addr;
		logic [GSIZE_W-1:0]   grant_size;
		logic                 region_emptied;
	} rsp_t;

	typedef struct packed {
		logic                         valid;
		logic [ADDR_BITS-1:0]         base;
		logic [CHUNKS_PER_REGION-1:0] bits;
	} entry_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PRE, S_SCAN1, S_EVAL1, S_SCAN2, S_EVAL2, S_FILL, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		RS_NONE, RS_PRE, RS_EVAL1, RS_EVAL2, RS_FILL
	} res_sel_t;

	typedef struct packed {
		logic     clr;
		logic     load;
		logic     scan_start;
		logic     scan_par;
		logic     scan_step;
		res_sel_t res_sel;
		logic     out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic pre_ok;
		logic scan_done;
		logic need_refill;
		logic par_ok;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== hw/rtl/bsca_ram.sv =====
// ----------------------------------------------------------------------------
// bsca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/bsca_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsca_ctrl
// Sequencer: clearing pass, table scans, updates and result hand-off.
// ----------------------------------------------------------------------------
module bsca_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  bsca_pkg::dp_stat_t stat,
	output bsca_pkg::ctl_cmd_t cmd
);

	import bsca_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n        = state_q;
		cmd            = '0;
		cmd.res_sel    = RS_NONE;
		req_stall      = (state_q != S_IDLE);
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_done) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_n  = S_PRE;
				end
			end
			S_PRE: begin
				if (stat.pre_ok) begin
					cmd.scan_start = 1'b1;
					state_n        = S_SCAN1;
				end else begin
					cmd.res_sel = RS_PRE;
					state_n     = S_DONE;
				end
			end
			S_SCAN1: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) state_n = S_EVAL1;
			end
			S_EVAL1: begin
				if (stat.need_refill) begin
					cmd.scan_start = 1'b1;
					cmd.scan_par   = 1'b1;
					state_n        = S_SCAN2;
				end else begin
					cmd.res_sel = RS_EVAL1;
					state_n     = S_DONE;
				end
			end
			S_SCAN2: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) state_n = S_EVAL2;
			end
			S_EVAL2: begin
				cmd.res_sel = RS_EVAL2;
				state_n     = stat.par_ok ? S_FILL : S_DONE;
			end
			S_FILL: begin
				cmd.res_sel = RS_FILL;
				state_n     = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_CLEAR;
		endcase
	end

endmodule

// ===== hw/rtl/bsca_dp.sv =====
// ----------------------------------------------------------------------------
// bsca_dp
// Region table, scan accumulators, chunk take/return logic and result register.
// ----------------------------------------------------------------------------
module bsca_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  bsca_pkg::req_t     req,
	input  bsca_pkg::ctl_cmd_t cmd,
	input  logic               rsp_stall,
	output bsca_pkg::dp_stat_t stat,
	output logic               rsp_valid,
	output bsca_pkg::rsp_t     rsp
);

	import bsca_pkg::*;

	localparam int CSH_W = $clog2(NUM_CLASSES + MIN_CHUNK_SHIFT + REFILL_STEP + 1);
	localparam int RS_W  = SIZE_W + 1;
	localparam int AW1   = ADDR_BITS + 1;
	localparam logic [CHUNKS_PER_REGION-1:0] ALL_FREE = '1;

	function automatic logic [CLS_W-1:0] size_class(input logic [SIZE_W-1:0] sz);
		logic [SIZE_W:0]  units;
		logic [SIZE_W:0]  n;
		logic [CLS_W-1:0] c;
		units = (RS_W'(sz) + RS_W'((1 << MIN_CHUNK_SHIFT) - 1)) >> MIN_CHUNK_SHIFT;
		n     = units - RS_W'(1);
		c     = '0;
		for (int i = 0; i <= SIZE_W; i++) begin
			if (n[i]) c = (i + 1 < NUM_CLASSES) ? CLS_W'(i + 1) : CLS_W'(NUM_CLASSES);
		end
		if (sz == '0 || c >= CLS_W'(NUM_CLASSES)) c = CLS_W'(NUM_CLASSES);
		return c;
	endfunction

	function automatic logic [BIT_W-1:0] low_bit(input logic [CHUNKS_PER_REGION-1:0] b);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = CHUNKS_PER_REGION - 1; i >= 0; i--) begin
			if (b[i]) r = BIT_W'(i);
		end
		return r;
	endfunction

	req_t             req_q;
	logic [CLS_W-1:0] cls_q;
	logic [TBL_AW-1:0] clr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rv_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [TBL_AW-1:0] sbase_q;
	logic             par_q;

	logic                         bfound_q, ffound_q, ovl_q, mfound_q;
	logic [TBL_AW-1:0]            bidx_q, fidx_q, midx_q;
	logic [ADDR_BITS-1:0]         bbase_q, mbase_q, pbase_q;
	logic [CHUNKS_PER_REGION-1:0] bbits_q, mbits_q;
	rsp_t                         res_q, res_n;
	rsp_t                         out_q;
	logic                         out_valid_q;

	logic                 we;
	logic [TBL_AW-1:0]    waddr, raddr, idx_s1;
	entry_t               wdata, rdata;
	logic                 cls_ok, cmd_ok, add_exact, range_bad, pre_bad;
	logic [ST_W-1:0]      pre_st;
	logic [CSH_W-1:0]     csh, tsh;
	logic [RS_W-1:0]      rsize;
	logic [AW1-1:0]       rsm1, base_w, end_new, end_e, top_sum;
	logic [GSIZE_W-1:0]   gsize;
	logic [BIT_W-1:0]     lb, rb;
	logic [CHUNKS_PER_REGION-1:0] take_bits, rmask, nbits;
	logic [ADDR_BITS-1:0] take_addr, roff;
	logic                 dbl, empt, ovl_e, better_e, inreg_e;
	logic [CLS_W:0]       cls_par;

	assign cls_ok   = cls_q < CLS_W'(NUM_CLASSES);
	assign cmd_ok   = req_q.cmd inside {CMD_ADD, CMD_ACQ, CMD_REL};
	assign csh      = CSH_W'(cls_q) + CSH_W'(MIN_CHUNK_SHIFT);
	assign tsh      = par_q ? csh + CSH_W'(REFILL_STEP) : csh;
	assign gsize    = (cls_ok && cmd_ok) ? GSIZE_W'(1) << csh : '0;
	assign rsize    = RS_W'(1) << (csh + CSH_W'(REGION_SHIFT));
	assign rsm1     = AW1'(rsize) - AW1'(1);
	assign base_w   = AW1'(req_q.req_addr);
	assign top_sum  = base_w + rsm1;
	assign add_exact = rsize == RS_W'(req_q.req_size);
	assign range_bad = top_sum[ADDR_BITS];
	assign cls_par  = (CLS_W + 1)'(cls_q) + (CLS_W + 1)'(REFILL_STEP);

	always_comb begin
		pre_bad = 1'b0;
		pre_st  = ST_OK;
		case (req_q.cmd)
			CMD_ADD: begin
				if (!cls_ok || !add_exact) begin
					pre_bad = 1'b1;
					pre_st  = ST_BADSIZE;
				end else if (range_bad) begin
					pre_bad = 1'b1;
					pre_st  = ST_BADADDR;
				end
			end
			CMD_ACQ, CMD_REL: begin
				if (!cls_ok) begin
					pre_bad = 1'b1;
					pre_st  = ST_BADSIZE;
				end
			end
			default: begin
				pre_bad = 1'b1;
				pre_st  = ST_BADSIZE;
			end
		endcase
	end

	assign raddr  = sbase_q + TBL_AW'(cnt_q[SLOT_W-1:0]);
	assign idx_s1 = sbase_q + TBL_AW'(slot_s1);
	assign end_e  = AW1'(rdata.base) + rsm1;
	assign end_new = top_sum;
	assign ovl_e  = rdata.valid && base_w <= end_e && AW1'(rdata.base) <= end_new;
	assign better_e = rdata.valid && (|rdata.bits) && (!bfound_q || rdata.base < bbase_q);
	assign inreg_e = rdata.valid && req_q.req_addr >= rdata.base &&
		AW1'(req_q.req_addr - rdata.base) < AW1'(rsize);

	assign lb        = low_bit(bbits_q);
	assign take_bits = bbits_q & ~(CHUNKS_PER_REGION'(1) << lb);
	assign take_addr = bbase_q + (ADDR_BITS'(lb) << tsh);
	assign roff      = req_q.req_addr - mbase_q;
	assign rb        = BIT_W'(roff >> csh);
	assign rmask     = CHUNKS_PER_REGION'(1) << rb;
	assign dbl       = |(mbits_q & rmask);
	assign nbits     = mbits_q | rmask;
	assign empt      = &nbits;

	always_comb begin
		res_n            = '0;
		res_n.grant_size = gsize;
		we               = 1'b0;
		waddr            = clr_q;
		wdata            = '0;
		if (cmd.clr) begin
			we = 1'b1;
		end
		unique case (cmd.res_sel)
			RS_NONE: res_n = res_q;
			RS_PRE:  res_n.status = pre_st;
			RS_EVAL1: begin
				case (req_q.cmd)
					CMD_ADD: begin
						if (ovl_q) begin
							res_n.status = ST_BADADDR;
						end else if (!ffound_q) begin
							res_n.status = ST_FULL;
						end else begin
							we    = 1'b1;
							waddr = fidx_q;
							wdata = '{valid: 1'b1, base: req_q.req_addr, bits: ALL_FREE};
						end
					end
					CMD_ACQ: begin
						if (bfound_q) begin
							we               = 1'b1;
							waddr            = bidx_q;
							wdata            = '{valid: 1'b1, base: bbase_q, bits: take_bits};
							res_n.grant_addr = take_addr;
						end else begin
							res_n.status = ST_NOSPACE;
						end
					end
					default: begin
						if (!mfound_q || dbl) begin
							res_n.status = ST_BADADDR;
						end else begin
							we                   = 1'b1;
							waddr                = midx_q;
							wdata                = '{valid: !empt, base: mbase_q, bits: nbits};
							res_n.region_emptied = empt;
						end
					end
				endcase
			end
			RS_EVAL2: begin
				if (!bfound_q) begin
					res_n.status = ST_NOSPACE;
				end else if (!ffound_q) begin
					res_n.status = ST_FULL;
				end else begin
					we    = 1'b1;
					waddr = bidx_q;
					wdata = '{valid: 1'b1, base: bbase_q, bits: take_bits};
				end
			end
			RS_FILL: begin
				we               = 1'b1;
				waddr            = fidx_q;
				wdata            = '{valid: 1'b1, base: pbase_q, bits: ALL_FREE << 1};
				res_n.grant_addr = pbase_q;
			end
			default: res_n = res_q;
		endcase
	end

	bsca_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_tbl (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + TBL_AW'(1);
			if (cmd.scan_start) begin
				cnt_q <= '0;
				rv_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				rv_s1 <= cnt_q < CNT_W'(REGIONS_PER_CLASS);
				if (cnt_q < CNT_W'(REGIONS_PER_CLASS)) cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			cls_q <= (req.cmd == CMD_ADD) ? size_class(req.req_size >> REGION_SHIFT)
				: size_class(req.req_size);
		end
		if (cmd.scan_start) begin
			par_q    <= cmd.scan_par;
			sbase_q  <= TBL_AW'(cmd.scan_par ? cls_par : (CLS_W + 1)'(cls_q)) *
				TBL_AW'(REGIONS_PER_CLASS);
			bfound_q <= 1'b0;
			ovl_q    <= 1'b0;
			mfound_q <= 1'b0;
			if (!cmd.scan_par) ffound_q <= 1'b0;
		end else if (cmd.scan_step && rv_s1) begin
			if (ovl_e) ovl_q <= 1'b1;
			if (better_e) begin
				bfound_q <= 1'b1;
				bidx_q   <= idx_s1;
				bbase_q  <= rdata.base;
				bbits_q  <= rdata.bits;
			end
			if (!par_q && !rdata.valid && !ffound_q) begin
				ffound_q <= 1'b1;
				fidx_q   <= idx_s1;
			end
			if (inreg_e && !mfound_q) begin
				mfound_q <= 1'b1;
				midx_q   <= idx_s1;
				mbase_q  <= rdata.base;
				mbits_q  <= rdata.bits;
			end
		end
		if (cmd.scan_step) slot_s1 <= cnt_q[SLOT_W-1:0];
		if (cmd.res_sel == RS_EVAL2) pbase_q <= take_addr;
		res_q <= res_n;
		if (cmd.out_load) out_q <= res_q;
	end

	assign stat.clr_done    = clr_q == TBL_AW'(TABLE_DEPTH - 1);
	assign stat.pre_ok      = !pre_bad;
	assign stat.scan_done   = cnt_q == CNT_W'(REGIONS_PER_CLASS) && !rv_s1;
	assign stat.need_refill = req_q.cmd == CMD_ACQ && !bfound_q &&
		cls_q <= CLS_W'(REFILL_MAX_CLASS) && cls_par < (CLS_W + 1)'(NUM_CLASSES);
	assign stat.par_ok      = bfound_q && ffound_q;
	assign stat.out_free    = !out_valid_q || !rsp_stall;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ===== hw/rtl/bitmap_size_class_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_size_class_allocator
// Power-of-two size-class chunk allocator over per-class region bitmaps.
//
//   channel  dir  payload            handshake
//   req      in   bsca_pkg::req_t    req_valid / req_stall
//   rsp      out  bsca_pkg::rsp_t    rsp_valid / rsp_stall
//
// One item at a time. An item makes one 64-slot scan of its class through
// the table RAM read port, then decides and writes; an acquire that
// refills from a larger class scans twice.
// An item rejected on its command, size or range skips the scan.
// After reset a clearing pass over all 704 table entries runs before the first item.
// A waiting result is held in the output register; the next item may
// start while it waits, and finishes once that register is free.
// ----------------------------------------------------------------------------
module bitmap_size_class_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bsca_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bsca_pkg::rsp_t rsp
);

	import bsca_pkg::*;

	ctl_cmd_t ctl_cmd;
	dp_stat_t dp_stat;

	bsca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (dp_stat),
		.cmd       (ctl_cmd)
	);

	bsca_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (ctl_cmd),
		.rsp_stall (rsp_stall),
		.stat      (dp_stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ===== hw/rtl/bsca_chk.sv =====
// ----------------------------------------------------------------------------
// bsca_chk
// Port-level checks of the size-class allocator.
// ----------------------------------------------------------------------------
module bsca_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input bsca_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input bsca_pkg::rsp_t rsp
);

	import bsca_pkg::*;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("item accepted while another is in work");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result changed");

	a_ok_sized: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_OK) |-> (rsp.grant_size != '0))
		else $error("ok result without a chunk size");

	a_emptied_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.region_emptied) |-> (rsp.status == ST_OK && rsp.grant_addr == '0))
		else $error("emptied flag on a failed or granting item");

endmodule

bind bitmap_size_class_allocator bsca_chk u_chk (.*);
